// ===== hdl/nma_pkg.sv =====
// nma_pkg: shared widths, constants, codes and structs of the neuron MAC/activation block.
// No dependencies; imported by every module under hdl/.
`default_nettype none

package nma_pkg;

   // Field widths
   localparam int X_W    = 16;          // Q4.12 input element and weight
   localparam int SIG_W  = 32;          // Q8.24 signal and activation
   localparam int VAL_W  = 25;          // unsigned Q1.24 up to one
   localparam int SUM_W  = 40;          // running sum
   localparam int Q_FRAC = 24;          // fraction bits of results

   // Activation table default depth
   localparam int ACT_TABLE_DEPTH_DEF = 1024;

   // Queue between front and back
   localparam int MID_DEPTH = 4;        // power of two
   localparam int CNT_W     = $clog2(MID_DEPTH + 1);

   // Fixed point constants
   localparam logic [VAL_W-1:0] ONE_Q24   = VAL_W'(1) << Q_FRAC;
   localparam logic [SIG_W-1:0] ONE_SIG   = SIG_W'(1) << Q_FRAC;
   localparam logic [SIG_W-1:0] CLAMP_Q24 = SIG_W'(20) << Q_FRAC;   // table span, 20.0

   // Divide by the table span: span = 5 << SPAN_SHIFT, the factor 5 by reciprocal
   localparam int SPAN_SHIFT = 26;
   localparam int FRAC_W     = 29;      // remainder modulo the span
   localparam int DIV_IN_W   = 28;      // widest dividend of the divide by 5
   localparam int DIV5_SHIFT = 30;
   localparam logic [DIV_IN_W-1:0] DIV5_MUL = DIV_IN_W'(214748365);   // ceil(2^30 / 5)

   // Activation modes
   typedef enum logic [1:0] {
      MODE_TANH     = 2'd0,
      MODE_LOGISTIC = 2'd1,
      MODE_LINEAR   = 2'd2,
      MODE_SIGN     = 2'd3
   } act_mode_type;

   localparam act_mode_type MODE_RESET = MODE_LOGISTIC;

   // Register map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE_ADDR = '0;

   // Front to queue: one finished signal
   typedef struct packed {
      logic                    valid;
      logic signed [SIG_W-1:0] signal;
   } mid_push_type;

   // Front status: finished vectors still on their way into the queue
   typedef struct packed {
      logic [1:0] pending;
   } front_status_type;

endpackage

`default_nettype wire

// ===== hdl/neuron_mac_activation_top.sv =====
// neuron_mac_activation_top: streaming dot product with selectable activation and derivative.
// Depends on nma_pkg, nma_front, nma_fifo and nma_back.
//
//   channel   ports                                  handshake
//   -------   ------------------------------------   ---------------------------------
//   request   req_x_value, req_weight_value,          push && !full
//             req_last
//   response  rsp_signal, rsp_activation,             pop && !empty
//             rsp_derivative
//   csr       paddr, pwdata, prdata                   psel && penable && pwrite (pready=1)
//
// One item per cycle is accepted while full is low; the front end accumulates the product
// of each accepted item. A vector's result then passes through the 10-stage activation
// pipeline (table ROM read, interpolation and derivative multipliers).
// Reset (synchronous) clears the sum, the queue, the pipeline and sets logistic mode.
// A held result stalls the activation pipeline; full rises once the 4-entry queue
// plus vectors still finishing in the front end would fill it.
`default_nettype none

module neuron_mac_activation_top
   import nma_pkg::*;
#(
   parameter int ACT_TABLE_DEPTH = ACT_TABLE_DEPTH_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic signed [X_W-1:0]   req_x_value,
   input  logic signed [X_W-1:0]   req_weight_value,
   input  logic                    req_last,
   output logic                    empty,
   input  logic                    pop,
   output logic signed [SIG_W-1:0] rsp_signal,
   output logic signed [SIG_W-1:0] rsp_activation,
   output logic [VAL_W-1:0]        rsp_derivative,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   act_mode_type            mode_ff, mode_in;
   logic                    in_accept;
   logic                    csr_write;
   mid_push_type            mid_push;
   front_status_type        front_status;
   logic signed [SIG_W-1:0] fifo_data;
   logic                    fifo_empty;
   logic                    fifo_pop;
   logic [CNT_W-1:0]        fifo_count;

   // Mode register
   always_comb begin
      csr_write = psel && penable && pwrite && pready;
      mode_in   = mode_ff;
      if (csr_write && paddr == CSR_MODE_ADDR) begin
         mode_in = act_mode_type'(pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_MODE_ADDR) ? CSR_DATA_W'(mode_ff) : '0;

   // Queue credit: count plus vectors still finishing in the front end
   assign full = ({1'b0, fifo_count} + (CNT_W+1)'(front_status.pending))
                 >= (CNT_W+1)'(MID_DEPTH);
   assign in_accept = push && !full;

   nma_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept_i       (in_accept),
      .x_value_i      (req_x_value),
      .weight_value_i (req_weight_value),
      .last_i         (req_last),
      .push_o         (mid_push),
      .status_o       (front_status)
   );

   nma_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_i  (mid_push),
      .pop_i   (fifo_pop),
      .data_o  (fifo_data),
      .empty_o (fifo_empty),
      .count_o (fifo_count)
   );

   nma_back #(
      .ACT_TABLE_DEPTH (ACT_TABLE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .mode_i           (mode_ff),
      .in_empty_i       (fifo_empty),
      .in_signal_i      (fifo_data),
      .in_pop_o         (fifo_pop),
      .out_pop_i        (pop),
      .out_empty_o      (empty),
      .out_signal_o     (rsp_signal),
      .out_activation_o (rsp_activation),
      .out_derivative_o (rsp_derivative)
   );

   // The credit scheme never lets the front end write into a full queue
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      mid_push.valid |-> (fifo_count < CNT_W'(MID_DEPTH)))
      else $error("front end pushed into a full queue");

   // A delivered derivative never exceeds one
   a_derivative_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_derivative <= ONE_Q24))
      else $error("derivative above one");

   // No result is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result present after reset");

endmodule

`default_nettype wire

// ===== hdl/nma_front.sv =====
// nma_front: multiply-accumulate front end; builds the saturated signal of each vector.
// Depends on nma_pkg.
`default_nettype none

module nma_front
   import nma_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept_i,
   input  logic signed [X_W-1:0]  x_value_i,
   input  logic signed [X_W-1:0]  weight_value_i,
   input  logic                   last_i,
   output mid_push_type           push_o,
   output front_status_type       status_o
);

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
   localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

   logic                    prod_valid_ff, prod_valid_in;
   logic                    prod_last_ff;
   logic signed [SIG_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    fin_valid_ff, fin_valid_in;
   logic signed [SUM_W-1:0] fin_ff;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_sat;
   logic [SUM_W-SIG_W:0]    fin_top;

   // Product stage
   always_comb begin
      prod_valid_in = accept_i;
      prod_in       = SIG_W'(x_value_i) * SIG_W'(weight_value_i);
   end

   // Accumulate with saturation at the 40-bit limits
   always_comb begin
      sum_wide = {sum_ff[SUM_W-1], sum_ff} + (SUM_W+1)'(prod_ff);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      sum_in       = sum_ff;
      fin_valid_in = prod_valid_ff && prod_last_ff;
      if (prod_valid_ff) begin
         sum_in = prod_last_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         fin_valid_ff  <= 1'b0;
         sum_ff        <= '0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         fin_valid_ff  <= fin_valid_in;
         sum_ff        <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_i) begin
         prod_ff      <= prod_in;
         prod_last_ff <= last_i;
      end
      if (fin_valid_in) begin
         fin_ff <= sum_sat;
      end
   end

   // Saturate the finished sum to the 32-bit signal
   always_comb begin
      fin_top       = fin_ff[SUM_W-1:SIG_W-1];
      push_o.valid  = fin_valid_ff;
      if (fin_top == '0 || fin_top == '1) begin
         push_o.signal = fin_ff[SIG_W-1:0];
      end else begin
         push_o.signal = fin_ff[SUM_W-1] ? SIG_MIN : SIG_MAX;
      end
      status_o.pending = {1'b0, prod_valid_ff && prod_last_ff} + {1'b0, fin_valid_ff};
   end

endmodule

`default_nettype wire

// ===== hdl/nma_fifo.sv =====
// nma_fifo: short queue of finished signals between the front and the back end.
// Depends on nma_pkg (MID_DEPTH, mid_push_type).
`default_nettype none

module nma_fifo
   import nma_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mid_push_type            push_i,
   input  logic                    pop_i,
   output logic signed [SIG_W-1:0] data_o,
   output logic                    empty_o,
   output logic [CNT_W-1:0]        count_o
);

   localparam int PTR_W = $clog2(MID_DEPTH);

   logic signed [SIG_W-1:0] mem_ff [MID_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_pop;

   // Pointer and fill count update
   always_comb begin
      do_pop    = pop_i && (count_ff != '0);
      wr_ptr_in = push_i.valid ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push_i.valid, do_pop})
         2'b10:   count_in = CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i.valid) begin
         mem_ff[wr_ptr_ff] <= push_i.signal;
      end
   end

   assign data_o  = mem_ff[rd_ptr_ff];
   assign empty_o = (count_ff == '0);
   assign count_o = count_ff;

endmodule

`default_nettype wire

// ===== hdl/nma_back.sv =====
// nma_back: activation pipeline (table interpolation, derivative) and result register.
// Depends on nma_pkg; holds the tanh and logistic tables as constant ROMs.
`default_nettype none

module nma_back
   import nma_pkg::*;
#(
   parameter int ACT_TABLE_DEPTH = ACT_TABLE_DEPTH_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  act_mode_type            mode_i,
   input  logic                    in_empty_i,
   input  logic signed [SIG_W-1:0] in_signal_i,
   output logic                    in_pop_o,
   input  logic                    out_pop_i,
   output logic                    out_empty_o,
   output logic signed [SIG_W-1:0] out_signal_o,
   output logic signed [SIG_W-1:0] out_activation_o,
   output logic [VAL_W-1:0]        out_derivative_o
);

   localparam int AW       = $clog2(ACT_TABLE_DEPTH + 1);
   localparam int PW       = SIG_W + AW;          // mag * depth
   localparam int SPAN_PW  = SIG_W + AW;          // index * span
   localparam int PRODW    = VAL_W + FRAC_W;      // slope * remainder
   localparam int DPW      = 2 * VAL_W;           // derivative product
   localparam int NSTG     = 10;
   localparam int TAB_BITS = (ACT_TABLE_DEPTH + 1) * VAL_W;

   // Table step h = 20 / depth in Q32
   localparam logic [63:0] TAB_STEP_Q32 = (64'd20 << 32) / 64'(ACT_TABLE_DEPTH);

   typedef struct packed {
      logic signed [SIG_W-1:0] signal;
      logic                    neg;
      logic                    clamp;
   } meta_type;

   // Unsigned restoring division, only evaluated while the tables are built
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Table build at elaboration: exp(-j h) by a rounded recurrence in Q32
   function automatic logic [TAB_BITS-1:0] build_tab(input logic want_tanh);
      logic [TAB_BITS-1:0] tab;
      logic [63:0]         h;
      logic [63:0]         term;
      logic [63:0]         q;
      logic [63:0]         f;
      logic [63:0]         d;
      int                  n;
      int                  j;
      tab  = '0;
      h    = TAB_STEP_Q32;
      term = 64'd1 << 32;
      q    = term;
      f    = 64'd1 << 32;
      for (n = 1; n <= 20; n++) begin
         term = udiv64((term * h) >> 32, 64'(n));
         if (n[0]) begin
            q = q - term;
         end else begin
            q = q + term;
         end
      end
      for (j = 0; j <= 2 * ACT_TABLE_DEPTH; j++) begin
         d = (64'd1 << 32) + f;
         if (!want_tanh && j <= ACT_TABLE_DEPTH) begin
            tab[j*VAL_W +: VAL_W] = VAL_W'(udiv64((64'd1 << 56) + (d >> 1), d));
         end
         if (want_tanh && !j[0]) begin
            tab[(j >> 1)*VAL_W +: VAL_W] = VAL_W'(udiv64(((64'd1 << 32) - f) << 24, d));
         end
         f = (f * q + (64'd1 << 31)) >> 32;
      end
      return tab;
   endfunction

   localparam logic [TAB_BITS-1:0] TANH_TAB = build_tab(1'b1);
   localparam logic [TAB_BITS-1:0] LOGI_TAB = build_tab(1'b0);

   // Exact floor(x / 5) for x below 2^28
   function automatic logic [DIV_IN_W-1:0] div5(input logic [DIV_IN_W-1:0] x);
      logic [2*DIV_IN_W-1:0] prod;
      prod = (2*DIV_IN_W)'(x) * (2*DIV_IN_W)'(DIV5_MUL);
      return DIV_IN_W'(prod >> DIV5_SHIFT);
   endfunction

   logic                    adv;
   logic                    v_ff [1:NSTG];
   meta_type                meta_ff [1:NSTG];
   meta_type                meta1_in;

   logic [SIG_W-1:0]        mag1_ff, mag1_in;
   logic [PW-1:0]           p2_ff, p2_in;
   logic [AW-1:0]           idx3_ff, idx3_in;
   logic [FRAC_W-1:0]       plow3_ff;
   logic [DIV_IN_W-1:0]     quot3;
   logic [AW-1:0]           idx_hi;
   logic [FRAC_W-1:0]       r4_ff, r4_in;
   logic [VAL_W-1:0]        lo4_ff, hi4_ff;
   logic [VAL_W-1:0]        diff5_ff, diff5_in;
   logic [VAL_W-1:0]        lo5_ff;
   logic [FRAC_W-1:0]       r5_ff;
   logic [PRODW-1:0]        prod6_ff, prod6_in;
   logic [VAL_W-1:0]        lo6_ff;
   logic [VAL_W-1:0]        quot7_ff, quot7_in;
   logic [VAL_W-1:0]        lo7_ff;
   logic [VAL_W-1:0]        value8_ff, value8_in;
   logic [SIG_W-1:0]        act9_ff, act9_in;
   logic [VAL_W-1:0]        opa9_ff, opa9_in;
   logic [VAL_W-1:0]        opb9_ff, opb9_in;
   logic [VAL_W-1:0]        lv9;
   logic [DPW-1:0]          dprod10_ff, dprod10_in;
   logic [SIG_W-1:0]        act10_ff;
   logic                    out_valid_ff;
   logic signed [SIG_W-1:0] out_signal_ff;
   logic [SIG_W-1:0]        out_act_ff;
   logic [VAL_W-1:0]        out_der_ff, out_der_in;

   // Whole pipeline moves when the result register is free or being taken
   assign adv      = !out_valid_ff || out_pop_i;
   assign in_pop_o = adv && !in_empty_i;

   // Stage 1: sign, magnitude and clamp test
   always_comb begin
      meta1_in.signal = in_signal_i;
      meta1_in.neg    = in_signal_i[SIG_W-1];
      meta1_in.clamp  = (in_signal_i >= $signed(CLAMP_Q24)) ||
                        (in_signal_i <= -$signed(CLAMP_Q24));
      mag1_in         = in_signal_i[SIG_W-1] ? SIG_W'(-in_signal_i) : in_signal_i;
   end

   // Stage 2: scale magnitude by table depth
   assign p2_in = PW'(mag1_ff) * PW'(ACT_TABLE_DEPTH);

   // Stage 3: table index = p / span
   always_comb begin
      quot3   = div5(DIV_IN_W'(p2_ff >> SPAN_SHIFT));
      idx3_in = meta_ff[2].clamp ? '0 : AW'(quot3);
   end

   // Stage 4: remainder, and both neighbors from the ROM
   always_comb begin
      idx_hi = AW'(idx3_ff + 1'b1);
      r4_in  = plow3_ff - FRAC_W'(SPAN_PW'(idx3_ff) * SPAN_PW'(CLAMP_Q24));
   end

   // Stages 5 to 8: interpolate lo + (hi - lo) * r / span
   always_comb begin
      diff5_in  = hi4_ff - lo4_ff;
      prod6_in  = PRODW'(diff5_ff) * PRODW'(r5_ff);
      quot7_in  = VAL_W'(div5(DIV_IN_W'(prod6_ff >> SPAN_SHIFT)));
      value8_in = lo7_ff + quot7_ff;
   end

   // Stage 9: activation and derivative operands
   always_comb begin
      lv9     = '0;
      act9_in = '0;
      opa9_in = '0;
      opb9_in = '0;
      unique case (mode_i)
         MODE_TANH: begin
            lv9     = meta_ff[8].clamp ? ONE_Q24 : value8_ff;
            act9_in = meta_ff[8].neg ? SIG_W'(-SIG_W'(lv9)) : SIG_W'(lv9);
            opa9_in = lv9;
            opb9_in = lv9;
         end
         MODE_LOGISTIC: begin
            if (meta_ff[8].clamp) begin
               lv9 = meta_ff[8].neg ? '0 : ONE_Q24;
            end else begin
               lv9 = meta_ff[8].neg ? VAL_W'(ONE_Q24 - value8_ff) : value8_ff;
            end
            act9_in = SIG_W'(lv9);
            opa9_in = lv9;
            opb9_in = VAL_W'(ONE_Q24 - lv9);
         end
         MODE_LINEAR: begin
            act9_in = meta_ff[8].signal;
         end
         MODE_SIGN: begin
            act9_in = meta_ff[8].neg ? SIG_W'(-ONE_SIG) : ONE_SIG;
         end
      endcase
   end

   // Stage 10: derivative product
   assign dprod10_in = DPW'(opa9_ff) * DPW'(opb9_ff);

   // Result stage: derivative
   always_comb begin
      unique case (mode_i)
         MODE_TANH:     out_der_in = VAL_W'(ONE_Q24 - VAL_W'(dprod10_ff >> Q_FRAC));
         MODE_LOGISTIC: out_der_in = VAL_W'(dprod10_ff >> Q_FRAC);
         MODE_LINEAR:   out_der_in = ONE_Q24;
         MODE_SIGN:     out_der_in = '0;
      endcase
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NSTG; k++) begin
            v_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff[1] <= !in_empty_i;
         for (int k = 2; k <= NSTG; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         out_valid_ff <= v_ff[NSTG];
      end
   end

   // Payload registers and ROM reads
   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[1] <= meta1_in;
         for (int k = 2; k <= NSTG; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         mag1_ff  <= mag1_in;
         p2_ff    <= p2_in;
         idx3_ff  <= idx3_in;
         plow3_ff <= p2_ff[FRAC_W-1:0];
         r4_ff    <= r4_in;
         if (mode_i == MODE_TANH) begin
            lo4_ff <= TANH_TAB[idx3_ff*VAL_W +: VAL_W];
            hi4_ff <= TANH_TAB[idx_hi*VAL_W +: VAL_W];
         end else begin
            lo4_ff <= LOGI_TAB[idx3_ff*VAL_W +: VAL_W];
            hi4_ff <= LOGI_TAB[idx_hi*VAL_W +: VAL_W];
         end
         diff5_ff      <= diff5_in;
         lo5_ff        <= lo4_ff;
         r5_ff         <= r4_ff;
         prod6_ff      <= prod6_in;
         lo6_ff        <= lo5_ff;
         quot7_ff      <= quot7_in;
         lo7_ff        <= lo6_ff;
         value8_ff     <= value8_in;
         act9_ff       <= act9_in;
         opa9_ff       <= opa9_in;
         opb9_ff       <= opb9_in;
         dprod10_ff    <= dprod10_in;
         act10_ff      <= act9_ff;
         out_signal_ff <= meta_ff[NSTG].signal;
         out_act_ff    <= act10_ff;
         out_der_ff    <= out_der_in;
      end
   end

   assign out_empty_o      = !out_valid_ff;
   assign out_signal_o     = out_signal_ff;
   assign out_activation_o = out_act_ff;
   assign out_derivative_o = out_der_ff;

endmodule

`default_nettype wire

// ===== verif/nma_checker.sv =====
// nma_checker: watches the request, response and CSR channels of neuron_mac_activation_top,
// predicts every response from its own accumulator and activation tables, and compares.
// Depends on nma_pkg for widths, the mode enum and the register map.
module nma_checker
   import nma_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    full,
   input  logic signed [X_W-1:0]   req_x_value,
   input  logic signed [X_W-1:0]   req_weight_value,
   input  logic                    req_last,
   input  logic                    empty,
   input  logic                    pop,
   input  logic signed [SIG_W-1:0] rsp_signal,
   input  logic signed [SIG_W-1:0] rsp_activation,
   input  logic [VAL_W-1:0]        rsp_derivative,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic                    pready,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   input  logic [CSR_DATA_W-1:0]   prdata,
   output int                      error_count,
   output int                      pending_count,
   output int                      items_seen,
   output int                      results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     LUT_DEPTH    = ACT_TABLE_DEPTH_DEF;
   localparam longint UNIT         = longint'(1) << Q_FRAC;
   localparam longint LUT_SPAN     = longint'(20) << Q_FRAC;
   localparam longint ACC_MAX      = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint ACC_MIN      = -(longint'(1) << (SUM_W - 1));
   localparam longint SIG_MAX      = (longint'(1) << (SIG_W - 1)) - 1;
   localparam longint SIG_MIN      = -(longint'(1) << (SIG_W - 1));
   localparam int     REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [SIG_W-1:0] signal;
      logic signed [SIG_W-1:0] activation;
      logic [VAL_W-1:0]        derivative;
   } neuron_result_type;

   longint            tanh_lut [0:LUT_DEPTH];
   longint            logistic_lut [0:LUT_DEPTH];
   longint            dot_sum;
   act_mode_type      act_mode;
   neuron_result_type expected_results [$];

   // Sample points on [0, 20]: exp(-step) from truncated Taylor terms, then powers of it
   function automatic void build_luts();
      longint unsigned step;
      longint unsigned term;
      longint unsigned ratio;
      longint unsigned decay;
      longint unsigned denom;
      step  = (64'd20 << 32) / LUT_DEPTH;
      term  = 64'd1 << 32;
      ratio = term;
      decay = term;
      for (int n = 1; n <= 20; n++) begin
         term = ((term * step) >> 32) / n;
         if (n % 2 == 1) ratio = ratio - term;
         else ratio = ratio + term;
      end
      for (int j = 0; j <= 2 * LUT_DEPTH; j++) begin
         denom = (64'd1 << 32) + decay;
         if (j <= LUT_DEPTH)
            logistic_lut[j] = longint'(((64'd1 << 56) + denom / 2) / denom);
         if (j % 2 == 0)
            tanh_lut[j / 2] = longint'((((64'd1 << 32) - decay) << 24) / denom);
         decay = (decay * ratio + (64'd1 << 31)) >> 32;
      end
   endfunction

   // Linear interpolation between table points, truncating division
   function automatic longint lut_interp(input bit use_tanh, input longint mag);
      longint scaled;
      longint idx;
      longint frac;
      longint lo;
      longint hi;
      scaled = mag * LUT_DEPTH;
      idx    = scaled / LUT_SPAN;
      frac   = scaled % LUT_SPAN;
      if (idx >= LUT_DEPTH) idx = LUT_DEPTH - 1;
      lo = use_tanh ? tanh_lut[idx] : logistic_lut[idx];
      hi = use_tanh ? tanh_lut[idx + 1] : logistic_lut[idx + 1];
      return lo + ((hi - lo) * frac) / LUT_SPAN;
   endfunction

   // Accumulate one element; on the last one queue the expected response
   function automatic void accumulate_item(input logic signed [X_W-1:0] x,
                                           input logic signed [X_W-1:0] w,
                                           input logic last_item);
      longint            sig;
      longint            mag;
      longint            act;
      longint            der;
      neuron_result_type res;
      dot_sum = dot_sum + longint'(x) * longint'(w);
      if (dot_sum > ACC_MAX) dot_sum = ACC_MAX;
      if (dot_sum < ACC_MIN) dot_sum = ACC_MIN;
      if (!last_item) return;

      sig = dot_sum;
      if (sig > SIG_MAX) sig = SIG_MAX;
      if (sig < SIG_MIN) sig = SIG_MIN;
      dot_sum = 0;
      mag = (sig < 0) ? -sig : sig;

      case (act_mode)
         MODE_TANH: begin
            if (mag >= LUT_SPAN) begin
               act = (sig < 0) ? -UNIT : UNIT;
            end else begin
               act = lut_interp(1'b1, mag);
               if (sig < 0) act = -act;
            end
            der = UNIT - ((act * act) >>> Q_FRAC);
         end
         MODE_LOGISTIC: begin
            if (mag >= LUT_SPAN) begin
               act = (sig < 0) ? 0 : UNIT;
            end else begin
               act = lut_interp(1'b0, mag);
               if (sig < 0) act = UNIT - act;
            end
            der = (act * (UNIT - act)) >>> Q_FRAC;
         end
         MODE_LINEAR: begin
            act = sig;
            der = UNIT;
         end
         default: begin
            act = (sig >= 0) ? UNIT : -UNIT;
            der = 0;
         end
      endcase
      if (der < 0) der = 0;
      if (der > UNIT) der = UNIT;

      res.signal     = sig[SIG_W-1:0];
      res.activation = act[SIG_W-1:0];
      res.derivative = der[VAL_W-1:0];
      expected_results.push_back(res);
   endfunction

   // Compare one accepted response with the oldest expectation
   task automatic check_result();
      neuron_result_type exp_res;
      if (expected_results.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t: unexpected response sig=%0d act=%0d der=%0d", $realtime,
                     rsp_signal, rsp_activation, rsp_derivative);
         return;
      end
      exp_res = expected_results.pop_front();
      results_checked++;
      if (rsp_signal !== exp_res.signal || rsp_activation !== exp_res.activation ||
          rsp_derivative !== exp_res.derivative) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t: response %0d mismatch mode=%s exp sig=%0d act=%0d der=%0d, got sig=%0d act=%0d der=%0d",
                     $realtime, results_checked, act_mode.name(), exp_res.signal,
                     exp_res.activation, exp_res.derivative, rsp_signal, rsp_activation,
                     rsp_derivative);
      end
   endtask

   initial begin
      error_count     = 0;
      pending_count   = 0;
      items_seen      = 0;
      results_checked = 0;
      dot_sum         = 0;
      act_mode        = MODE_RESET;
      build_luts();
   end

   // Channel monitor: CSR first, then request, then response transaction
   always @(posedge clock) begin
      if (reset) begin
         dot_sum  = 0;
         act_mode = MODE_RESET;
         expected_results.delete();
      end else begin
         if (psel && penable && pready && paddr == CSR_MODE_ADDR) begin
            if (pwrite) begin
               act_mode = act_mode_type'(pwdata[1:0]);
            end else if (prdata !== CSR_DATA_W'(act_mode)) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: mode readback mismatch exp=%0d got=%0d", $realtime,
                           act_mode, prdata);
            end
         end
         if (push && !full) begin
            items_seen++;
            accumulate_item(req_x_value, req_weight_value, req_last);
         end
         if (pop && !empty) check_result();
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== verif/tb_neuron_mac_activation_top.sv =====
// tb_neuron_mac_activation_top: drives vectors, mode writes and response back-pressure into
// neuron_mac_activation_top; nma_checker predicts and compares. Depends on nma_pkg.
module tb_neuron_mac_activation_top
   import nma_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int GAP_MAX      = 18;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 480;
   localparam int PHASE_COUNT  = 6;
   localparam int EDGE_COUNT   = 9;
   localparam int SAT_RUN      = 514;

   typedef enum int {
      KIND_WIDE,
      KIND_MODERATE,
      KIND_TINY,
      KIND_EDGE
   } operand_kind_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    push = 1'b0;
   logic                    full;
   logic signed [X_W-1:0]   req_x_value = '0;
   logic signed [X_W-1:0]   req_weight_value = '0;
   logic                    req_last = 1'b0;
   logic                    empty;
   logic                    pop = 1'b0;
   logic signed [SIG_W-1:0] rsp_signal;
   logic signed [SIG_W-1:0] rsp_activation;
   logic [VAL_W-1:0]        rsp_derivative;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr = '0;
   logic [CSR_DATA_W-1:0]   pwdata = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   int error_count;
   int pending_count;
   int items_seen;
   int results_checked;
   int cycle_count = 0;
   int random_sent = 0;
   bit src_burst = 1'b0;
   bit src_fast = 1'b0;
   bit sink_burst = 1'b0;
   bit sink_hold_request = 1'b0;

   neuron_mac_activation_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_x_value      (req_x_value),
      .req_weight_value (req_weight_value),
      .req_last         (req_last),
      .empty            (empty),
      .pop              (pop),
      .rsp_signal       (rsp_signal),
      .rsp_activation   (rsp_activation),
      .rsp_derivative   (rsp_derivative),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   nma_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_x_value      (req_x_value),
      .req_weight_value (req_weight_value),
      .req_last         (req_last),
      .empty            (empty),
      .pop              (pop),
      .rsp_signal       (rsp_signal),
      .rsp_activation   (rsp_activation),
      .rsp_derivative   (rsp_derivative),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .items_seen       (items_seen),
      .results_checked  (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d responses still outstanding", cycle_count,
               pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // APB transaction on the mode register; the checker compares read data
   task automatic csr_access(input logic is_write, input act_mode_type mode);
      logic [CSR_DATA_W-1:0] data;
      data      = $urandom();
      data[1:0] = mode;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_MODE_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // One request transaction; push stays high on return so back-to-back items need no gap
   task automatic send_item(input logic signed [X_W-1:0] x, input logic signed [X_W-1:0] w,
                            input logic last_item);
      int gap;
      gap = (src_fast || src_burst) ? 0 : $urandom_range(0, GAP_MAX);
      if ($urandom_range(0, 15) == 0) src_burst = !src_burst;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push             <= 1'b1;
      req_x_value      <= x;
      req_weight_value <= w;
      req_last         <= last_item;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // Products landing on, just inside and just past the +-20 clamp, plus near zero
   task automatic edge_operands(input int pick, output logic signed [X_W-1:0] x,
                                output logic signed [X_W-1:0] w);
      case (pick)
         0:       begin x = 16'sd16384;  w = 16'sd20480; end
         1:       begin x = -16'sd16384; w = 16'sd20480; end
         2:       begin x = 16'sd16384;  w = 16'sd20479; end
         3:       begin x = -16'sd16384; w = 16'sd20479; end
         4:       begin x = 16'sd16384;  w = 16'sd20481; end
         5:       begin x = 16'sd0;      w = 16'sd0;     end
         6:       begin x = 16'sd1;      w = 16'sd1;     end
         7:       begin x = -16'sd1;     w = 16'sd1;     end
         default: begin x = 16'sd2048;   w = -16'sd2048; end
      endcase
   endtask

   // One vector of random content; edge kind is a single-element vector
   task automatic send_vector(input operand_kind_type kind);
      int                    len;
      logic signed [X_W-1:0] x;
      logic signed [X_W-1:0] w;
      if (kind == KIND_EDGE) begin
         edge_operands($urandom_range(0, EDGE_COUNT - 1), x, w);
         send_item(x, w, 1'b1);
         random_sent++;
         return;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
         case (kind)
            KIND_WIDE: begin
               x = X_W'($urandom());
               w = X_W'($urandom());
            end
            KIND_MODERATE: begin
               x = X_W'(int'($urandom_range(0, 16383)) - 8192);
               w = X_W'(int'($urandom_range(0, 16383)) - 8192);
            end
            default: begin
               x = X_W'(int'($urandom_range(0, 1023)) - 512);
               w = X_W'(int'($urandom_range(0, 1023)) - 512);
            end
         endcase
         send_item(x, w, k == len - 1);
         random_sent++;
      end
   endtask

   // Drive the 40-bit sum past its upper rail; a wrapping sum would come out negative
   task automatic saturate_accumulator();
      src_fast = 1'b1;
      repeat (SAT_RUN - 1) send_item(-16'sd32768, -16'sd32768, 1'b0);
      send_item(-16'sd32768, -16'sd32768, 1'b1);
      src_fast = 1'b0;
   endtask

   // Stop offering and wait for every expected response plus pipeline slack
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Response side: random pop gaps, bursts, and one long hold-off on request
   initial begin : response_sink
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = sink_burst ? 0 : $urandom_range(0, GAP_MAX);
         if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      act_mode_type     phase_mode;
      operand_kind_type kind;
      int               roll;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vectors in the reset mode (logistic), readback of reset value first
      csr_access(1'b0, MODE_RESET);
      send_item(16'sd32767, 16'sd32767, 1'b1);
      send_item(-16'sd32768, -16'sd32768, 1'b1);
      send_item(-16'sd32768, 16'sd32767, 1'b1);
      send_item(16'sd0, 16'sd0, 1'b1);
      for (int e = 0; e < EDGE_COUNT - 1; e++) begin
         logic signed [X_W-1:0] ex;
         logic signed [X_W-1:0] ew;
         edge_operands(e, ex, ew);
         send_item(ex, ew, 1'b1);
      end
      // signal saturates high, then low
      send_item(-16'sd32768, -16'sd32768, 1'b0);
      send_item(-16'sd32768, -16'sd32768, 1'b0);
      send_item(-16'sd32768, -16'sd32768, 1'b1);
      send_item(-16'sd32768, 16'sd32767, 1'b0);
      send_item(-16'sd32768, 16'sd32767, 1'b0);
      send_item(-16'sd32768, 16'sd32767, 1'b1);
      // partial sums cancel before the last element
      send_item(16'sd4096, 16'sd4096, 1'b0);
      send_item(-16'sd4096, 16'sd4096, 1'b0);
      send_item(16'sh1234, -16'sh0800, 1'b1);
      settle();

      // Random phases, one mode setting each
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       phase_mode = MODE_TANH;
            1:       phase_mode = MODE_SIGN;
            2:       phase_mode = MODE_LINEAR;
            3:       phase_mode = MODE_LOGISTIC;
            default: phase_mode = act_mode_type'($urandom_range(0, 3));
         endcase
         csr_access(1'b1, phase_mode);
         csr_access(1'b0, phase_mode);
         if (p == 1) begin
            // receiver stalls while single-element vectors stream in at full rate
            sink_hold_request = 1'b1;
            src_fast = 1'b1;
            repeat (40) send_vector(KIND_EDGE);
            src_fast = 1'b0;
         end
         if (p == 2) saturate_accumulator();
         while (random_sent < (p + 1) * RANDOM_ITEMS / PHASE_COUNT) begin
            roll = $urandom_range(0, 15);
            if (roll < 4) kind = KIND_WIDE;
            else if (roll < 11) kind = KIND_MODERATE;
            else if (roll < 13) kind = KIND_TINY;
            else kind = KIND_EDGE;
            send_vector(kind);
         end
         settle();
      end

      $display("Run: %0d request and %0d response transactions over %0d mode phases,",
               items_seen, results_checked, PHASE_COUNT);
      $display("including clamp edges, 40-bit sum saturation and a %0d-cycle response stall.",
               HOLD_CYCLES);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
